### rtl/core/tcp_stream_reassembler_unit_defines.svh
// assertion macros shared by the reassembler rtl
`ifndef TCP_STREAM_REASSEMBLER_UNIT_DEFINES_SVH
`define TCP_STREAM_REASSEMBLER_UNIT_DEFINES_SVH

// same-cycle implication, held off while reset is asserted
`define TSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, held off while reset is asserted
`define TSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### rtl/core/tsr_pkg.sv
`default_nettype none
package tsr_pkg;

	// window size in bytes
	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// field widths
	localparam int KIND_W  = 2;
	localparam int INDEX_W = 32;
	localparam int DATA_W  = 8;
	localparam int RCNT_W  = 6;
	localparam int PEND_W  = 6;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEG_END = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ    = 2'd2;

	// result kinds
	localparam logic OUT_DATA   = 1'b0;
	localparam logic OUT_STATUS = 1'b1;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [DATA_W-1:0]  data_t;
	typedef logic [RCNT_W-1:0]  rcnt_t;
	typedef logic [PEND_W-1:0]  pend_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic apply;
		logic scan;
		logic close;
		logic emit_data;
		logic emit_status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic do_scan;
		logic scan_done;
		logic has_drain;
		logic drain_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/tsr_in_if.sv
`default_nettype none
interface tsr_in_if;
	import tsr_pkg::*;

	logic   valid;
	logic   ready;
	kind_t  kind;
	index_t stream_index;
	data_t  data_byte;
	logic   segment_end;
	logic   eof_mark;
	rcnt_t  read_count;

	modport source (
		output valid, kind, stream_index, data_byte, segment_end, eof_mark, read_count,
		input  ready
	);

	modport sink (
		input  valid, kind, stream_index, data_byte, segment_end, eof_mark, read_count,
		output ready
	);

endinterface
`default_nettype wire

### rtl/core/tsr_out_if.sv
`default_nettype none
interface tsr_out_if;
	import tsr_pkg::*;

	logic   valid;
	logic   ready;
	logic   out_kind;
	data_t  out_byte;
	index_t ack_seq;
	pend_t  pending_count;
	logic   stream_ended;
	logic   last;

	modport source (
		output valid, out_kind, out_byte, ack_seq, pending_count, stream_ended, last,
		input  ready
	);

	modport sink (
		input  valid, out_kind, out_byte, ack_seq, pending_count, stream_ended, last,
		output ready
	);

endinterface
`default_nettype wire

### rtl/core/tsr_ram.sv
`default_nettype none
module tsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/tsr_ctrl.sv
`default_nettype none
module tsr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tsr_pkg::sts_t sts,
	output tsr_pkg::cmd_t      cmd
);
	import tsr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_APPLY  = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_CLOSE  = 3'd3;
	localparam logic [2:0] S_READ   = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;
	localparam logic [2:0] S_STATUS = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and command decode
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = sts.do_scan ? S_SCAN : S_CLOSE;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_CLOSE;
				end
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = sts.has_drain ? S_READ : S_STATUS;
			end
			S_READ: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_data = 1'b1;
					state_d       = sts.drain_last ? S_STATUS : S_READ;
				end
			end
			S_STATUS: begin
				if (sts.out_free) begin
					cmd.emit_status = 1'b1;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/tsr_datapath.sv
`default_nettype none
module tsr_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tsr_pkg::cmd_t   cmd,
	output tsr_pkg::sts_t        sts,
	input  wire tsr_pkg::kind_t  kind,
	input  wire tsr_pkg::index_t stream_index,
	input  wire tsr_pkg::data_t  data_byte,
	input  wire logic            segment_end,
	input  wire logic            eof_mark,
	input  wire tsr_pkg::rcnt_t  read_count,
	output logic                 res_valid,
	input  wire logic            res_ready,
	output logic                 out_kind,
	output tsr_pkg::data_t       out_byte,
	output tsr_pkg::index_t      ack_seq,
	output tsr_pkg::pend_t       pending_count,
	output logic                 stream_ended,
	output logic                 last
);
	import tsr_pkg::*;

	// latched input beat
	kind_t  kind_q;
	index_t idx_q;
	data_t  byte_q;
	logic   seg_end_q;
	logic   eof_q;
	rcnt_t  rcnt_q;

	// reassembly state
	index_t              head_q;
	logic [CNT_W-1:0]    outst_q;
	logic [CNT_W-1:0]    pend_q;
	logic                ovf_q;
	logic                eof_l_q;
	logic                ended_q;
	logic [CAPACITY-1:0] valid_q;
	logic [IDX_W-1:0]    base_q;
	logic [IDX_W-1:0]    scan_ptr_q;
	logic [CNT_W-1:0]    scan_cnt_q;
	logic [CNT_W-1:0]    rem_q;

	// output register
	logic   res_valid_q;
	logic   out_kind_q;
	data_t  out_byte_q;
	index_t ack_q;
	pend_t  pend_out_q;
	logic   ended_out_q;
	logic   last_q;

	// combinational helpers
	index_t           off;
	logic             at_or_above;
	logic [CNT_W-1:0] wlen;
	logic             fits;
	logic [IDX_W:0]   slot_sum;
	logic [IDX_W-1:0] wr_slot;
	logic             wr_en;
	logic             cur_valid;
	logic             scan_done;
	logic [CNT_W-1:0] pend_after;
	logic             close_en;
	logic             eof_next;
	rcnt_t            outst_wide;
	data_t            rd_data;
	logic             out_free;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		ptr_inc = (p == IDX_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
	endfunction

	// window check and physical slot of the incoming byte
	assign off         = idx_q - head_q;
	assign at_or_above = (idx_q >= head_q);
	assign wlen        = CNT_W'(CAPACITY) - outst_q;
	assign fits        = (off < INDEX_W'(wlen));
	assign slot_sum    = (IDX_W + 1)'(base_q) + (IDX_W + 1)'(off[IDX_W-1:0]);
	assign wr_slot     = (slot_sum >= (IDX_W + 1)'(CAPACITY)) ?
		IDX_W'(slot_sum - (IDX_W + 1)'(CAPACITY)) : IDX_W'(slot_sum);
	assign wr_en       = cmd.apply && (kind_q == KIND_BYTE) && at_or_above && fits;

	// head run scan, one slot per cycle
	assign cur_valid = valid_q[scan_ptr_q];
	assign scan_done = !(cur_valid && (scan_cnt_q != CNT_W'(CAPACITY)));

	// segment close terms
	assign pend_after = pend_q - scan_cnt_q;
	assign close_en   = ((kind_q == KIND_BYTE) && seg_end_q) || (kind_q == KIND_SEG_END);
	assign eof_next   = eof_l_q || (eof_q && !ovf_q);
	assign outst_wide = RCNT_W'(outst_q);

	assign out_free = !res_valid_q || res_ready;

	// status to controller
	always_comb begin
		sts.do_scan    = (kind_q == KIND_BYTE);
		sts.scan_done  = scan_done;
		sts.has_drain  = (scan_cnt_q != '0);
		sts.drain_last = (rem_q == CNT_W'(1));
		sts.out_free   = out_free;
	end

	// byte store
	tsr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_slot),
		.wdata (byte_q),
		.raddr (base_q),
		.rdata (rd_data)
	);

	// input beat capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q    <= kind;
			idx_q     <= stream_index;
			byte_q    <= data_byte;
			seg_end_q <= segment_end;
			eof_q     <= eof_mark;
			rcnt_q    <= read_count;
		end
	end

	// reassembly state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			outst_q    <= '0;
			pend_q     <= '0;
			ovf_q      <= 1'b0;
			eof_l_q    <= 1'b0;
			ended_q    <= 1'b0;
			valid_q    <= '0;
			base_q     <= '0;
			scan_ptr_q <= '0;
			scan_cnt_q <= '0;
			rem_q      <= '0;
		end else begin
			if (cmd.apply) begin
				scan_ptr_q <= base_q;
				scan_cnt_q <= '0;
				if (kind_q == KIND_BYTE && at_or_above) begin
					if (fits) begin
						valid_q[wr_slot] <= 1'b1;
						ovf_q            <= 1'b0;
						if (!valid_q[wr_slot]) begin
							pend_q <= pend_q + CNT_W'(1);
						end
					end else begin
						ovf_q <= 1'b1;
					end
				end
				if (kind_q == KIND_READ) begin
					outst_q <= (rcnt_q >= outst_wide) ? '0 : CNT_W'(outst_wide - rcnt_q);
				end
			end
			if (cmd.scan && !scan_done) begin
				scan_cnt_q <= scan_cnt_q + CNT_W'(1);
				scan_ptr_q <= ptr_inc(scan_ptr_q);
			end
			if (cmd.close) begin
				head_q  <= head_q + INDEX_W'(scan_cnt_q);
				pend_q  <= pend_after;
				outst_q <= outst_q + scan_cnt_q;
				rem_q   <= scan_cnt_q;
				if (close_en) begin
					eof_l_q <= eof_next;
					if (eof_next && (pend_after == '0) && !ovf_q) begin
						ended_q <= 1'b1;
					end
				end
			end
			if (cmd.emit_data) begin
				valid_q[base_q] <= 1'b0;
				base_q          <= ptr_inc(base_q);
				rem_q           <= rem_q - CNT_W'(1);
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_data || cmd.emit_status) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit_data || cmd.emit_status) begin
			out_kind_q  <= cmd.emit_status ? OUT_STATUS : OUT_DATA;
			out_byte_q  <= cmd.emit_status ? '0 : rd_data;
			ack_q       <= head_q;
			pend_out_q  <= PEND_W'(pend_q);
			ended_out_q <= ended_q;
			last_q      <= cmd.emit_status;
		end
	end

	assign res_valid     = res_valid_q;
	assign out_kind      = out_kind_q;
	assign out_byte      = out_byte_q;
	assign ack_seq       = ack_q;
	assign pending_count = pend_out_q;
	assign stream_ended  = ended_out_q;
	assign last          = last_q;

endmodule
`default_nettype wire

### rtl/core/tcp_stream_reassembler_unit.sv
// Byte stream reassembly window. Each input beat is a stream byte tagged with its absolute
// index, an empty segment end, or a count of bytes the reader consumed. Bytes land in a
// circular window of CAPACITY slots with a valid bit each; after every segment byte the
// contiguous run at the head is released in order, and every input beat closes with one
// status result (last set) carrying the ack index, pending count and end-of-stream bit as
// they stand after that beat; the data results of the beat carry the same values. One beat
// is taken at a time: a segment end or reader beat steps through apply, close and status, a
// segment byte adds a scan of the head run and a read and emit step per released byte, and
// the result side can stall each emit. The head run is found by a scan of one valid bit per
// cycle; each released byte is read from the registered byte store into the result register.
// A new beat is accepted while the closing status result still waits to be taken.
`default_nettype none
`include "tcp_stream_reassembler_unit_defines.svh"
module tcp_stream_reassembler_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tsr_in_if.sink     item,
	tsr_out_if.source  result
);
	import tsr_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic       ctrl_ready;
	logic [5:0] cmd_vec;

	// sequencing
	tsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (ctrl_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// window state, byte store and result register
	tsr_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.kind          (item.kind),
		.stream_index  (item.stream_index),
		.data_byte     (item.data_byte),
		.segment_end   (item.segment_end),
		.eof_mark      (item.eof_mark),
		.read_count    (item.read_count),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.out_kind      (result.out_kind),
		.out_byte      (result.out_byte),
		.ack_seq       (result.ack_seq),
		.pending_count (result.pending_count),
		.stream_ended  (result.stream_ended),
		.last          (result.last)
	);

	assign item.ready = ctrl_ready;

	assign cmd_vec = cmd;

	// checks
	`TSR_ASSERT_IMP(a_cmd_exclusive, clk, arst_n, 1'b1, $onehot0(cmd_vec))
	`TSR_ASSERT_IMP(a_emit_when_free, clk, arst_n, cmd.emit_data, sts.out_free)
	`TSR_ASSERT_NEXT(a_status_shows_last, clk, arst_n, cmd.emit_status,
		result.valid && result.last)
	`TSR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item.valid && item.ready,
		!item.ready)

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import tsr_pkg::*;

	// kind code with no defined action
	localparam kind_t KIND_UNUSED = 2'd3;

	localparam int RAND_BEATS  = 270;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT  = 4000;
	localparam int TAIL_CYCLES = 150;

	typedef struct packed {
		kind_t  kind;
		index_t idx;
		data_t  data;
		logic   seg_end;
		logic   eof;
		rcnt_t  rcnt;
	} beat_t;

	// status values typed in by hand, used when on is set
	typedef struct packed {
		logic   on;
		index_t ack;
		pend_t  pend;
		logic   ended;
	} status_chk_t;

	typedef struct packed {
		beat_t       b;
		status_chk_t chk;
	} row_t;

	typedef struct packed {
		logic   out_kind;
		data_t  out_byte;
		index_t ack;
		pend_t  pend;
		logic   ended;
		logic   last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n;

	tsr_in_if  item_if ();
	tsr_out_if result_if ();

	tcp_stream_reassembler_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// window model
	data_t       win_byte [CAPACITY];
	logic        win_mark [CAPACITY];
	index_t      ack_head;
	int unsigned unread;
	logic        overflow_q;
	logic        eof_seen;
	logic        ended_q;

	res_t expected_results [$];

	int errors     = 0;
	int beats_in   = 0;
	int n_results  = 0;
	int n_data     = 0;
	int max_drain  = 0;
	res_t got_want;

	localparam int N_ROWS = 16;
	row_t dir_rows [N_ROWS] = '{
		'{'{KIND_SEG_END, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_UNUSED,  32'hFFFF_FFFF, 8'hFF, 1'b1, 1'b1, 6'd63}, '{1'b1, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_BYTE,    32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0, 6'd63}, '{1'b1, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_SEG_END, 32'h0000_0000, 8'h00, 1'b0, 1'b1, 6'd0},  '{1'b1, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_BYTE,    32'd1,         8'hAA, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd0, 6'd1, 1'b0}},
		'{'{KIND_BYTE,    32'd31,        8'h00, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd0, 6'd2, 1'b0}},
		'{'{KIND_BYTE,    32'd32,        8'h5A, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd0, 6'd2, 1'b0}},
		'{'{KIND_BYTE,    32'd0,         8'h55, 1'b1, 1'b0, 6'd0},  '{1'b0, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_BYTE,    32'd0,         8'h77, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd2, 6'd1, 1'b0}},
		'{'{KIND_READ,    32'd0,         8'h00, 1'b0, 1'b0, 6'd63}, '{1'b1, 32'd2, 6'd1, 1'b0}},
		'{'{KIND_READ,    32'd0,         8'h00, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd2, 6'd1, 1'b0}},
		'{'{KIND_BYTE,    32'd2,         8'h12, 1'b1, 1'b0, 6'd0},  '{1'b0, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_BYTE,    32'h8000_0000, 8'h80, 1'b1, 1'b1, 6'd0},  '{1'b1, 32'd3, 6'd1, 1'b0}},
		'{'{KIND_BYTE,    32'd4,         8'h01, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd3, 6'd2, 1'b0}},
		'{'{KIND_BYTE,    32'd3,         8'hFE, 1'b0, 1'b0, 6'd0},  '{1'b0, 32'd0, 6'd0, 1'b0}},
		'{'{KIND_SEG_END, 32'h0000_0000, 8'h00, 1'b0, 1'b0, 6'd0},  '{1'b1, 32'd5, 6'd1, 1'b0}}
	};

	function automatic int unsigned room();
		return (unread >= CAPACITY) ? 0 : CAPACITY - unread;
	endfunction

	function automatic int unsigned held_count();
		int unsigned n;
		n = 0;
		for (int k = 0; k < CAPACITY; k++)
			if (win_mark[k])
				n++;
		return n;
	endfunction

	function automatic void close_segment(logic eof);
		if (eof && !overflow_q)
			eof_seen = 1'b1;
		if (eof_seen && held_count() == 0 && !overflow_q)
			ended_q = 1'b1;
	endfunction

	function automatic void clear_window();
		for (int k = 0; k < CAPACITY; k++) begin
			win_byte[k] = '0;
			win_mark[k] = 1'b0;
		end
		ack_head   = '0;
		unread     = 0;
		overflow_q = 1'b0;
		eof_seen   = 1'b0;
		ended_q    = 1'b0;
	endfunction

	// apply one accepted beat to the window and queue what it releases
	function automatic void predict_beat(beat_t b, status_chk_t chk);
		data_t  drained [$];
		index_t off;
		res_t   r;
		case (b.kind)
			KIND_BYTE: begin
				if (b.idx >= ack_head) begin
					off = b.idx - ack_head;
					if (off < room()) begin
						win_byte[off] = b.data;
						win_mark[off] = 1'b1;
						overflow_q = 1'b0;
					end else begin
						overflow_q = 1'b1;
					end
				end
				// release the contiguous run at the head
				while (win_mark[0] && room() > 0 && drained.size() < CAPACITY) begin
					drained.insert(drained.size(), win_byte[0]);
					for (int k = 0; k < CAPACITY - 1; k++) begin
						win_byte[k] = win_byte[k+1];
						win_mark[k] = win_mark[k+1];
					end
					win_byte[CAPACITY-1] = '0;
					win_mark[CAPACITY-1] = 1'b0;
					ack_head = ack_head + 1;
					unread++;
				end
				if (b.seg_end)
					close_segment(b.eof);
			end
			KIND_SEG_END: close_segment(b.eof);
			KIND_READ: unread = (b.rcnt >= unread) ? 0 : unread - b.rcnt;
			default: ;
		endcase
		if (drained.size() > max_drain)
			max_drain = drained.size();
		r.ack   = ack_head;
		r.pend  = pend_t'(held_count());
		r.ended = ended_q;
		foreach (drained[i]) begin
			r.out_kind = OUT_DATA;
			r.out_byte = drained[i];
			r.last     = 1'b0;
			expected_results.insert(expected_results.size(), r);
		end
		r.out_kind = OUT_STATUS;
		r.out_byte = '0;
		r.last     = 1'b1;
		if (chk.on) begin
			r.ack   = chk.ack;
			r.pend  = chk.pend;
			r.ended = chk.ended;
		end
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic beat_t mk_beat(kind_t k, index_t i, data_t d, logic s, logic e, rcnt_t r);
		beat_t b;
		b.kind    = k;
		b.idx     = i;
		b.data    = d;
		b.seg_end = s;
		b.eof     = e;
		b.rcnt    = r;
		return b;
	endfunction

	// no idling in a stretch of the run, otherwise mostly short gaps
	function automatic int idle_len();
		int r;
		if (beats_in >= 200 && beats_in < 240)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one beat, valid stays high after the handshake
	task automatic send_beat(beat_t b, status_chk_t chk);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.valid        <= 1'b1;
		item_if.kind         <= b.kind;
		item_if.stream_index <= b.idx;
		item_if.data_byte    <= b.data;
		item_if.segment_end  <= b.seg_end;
		item_if.eof_mark     <= b.eof;
		item_if.read_count   <= b.rcnt;
		do @(posedge clk); while (!(item_if.valid && item_if.ready));
		predict_beat(b, chk);
		beats_in++;
	endtask

	task automatic drop_valid();
		@(negedge clk);
		item_if.valid <= 1'b0;
	endtask

	task automatic run_random();
		int     sent;
		int     pick;
		int     groups;
		int     len;
		int     j;
		bit     paused;
		index_t next_seq;
		beat_t  grp_q [$];
		beat_t  tmp;
		sent = 0;
		paused = 1'b0;
		next_seq = ack_head;
		while (sent < RAND_BEATS) begin
			// let the result side drain completely once
			if (!paused && sent >= 150) begin
				drop_valid();
				while (expected_results.size() != 0)
					@(posedge clk);
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				// noise anywhere in the index space
				send_beat(mk_beat(kind_t'($urandom_range(0, 3)), $urandom(), data_t'($urandom()),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rcnt_t'($urandom())),
					'0);
				sent++;
			end else if (pick < 35) begin
				// reader frees part of the window
				send_beat(mk_beat(KIND_READ, $urandom(), data_t'($urandom()), 1'b0, 1'b0,
					($urandom_range(0, 9) == 0) ? rcnt_t'($urandom_range(0, 63))
						: rcnt_t'($urandom_range(1, 12))), '0);
				sent++;
			end else begin
				// retransmit from the head now and then, or when far ahead
				if (next_seq - ack_head > 40 || $urandom_range(0, 3) == 0)
					next_seq = ack_head - $urandom_range(0, 2);
				grp_q.delete();
				groups = $urandom_range(1, 3);
				for (int g = 0; g < groups; g++) begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
					for (int i = 0; i < len; i++) begin
						if (i == len - 1 && $urandom_range(0, 3) == 0) begin
							grp_q.insert(grp_q.size(), mk_beat(KIND_BYTE, next_seq + i,
								data_t'($urandom()), 1'b0, 1'b0, rcnt_t'($urandom())));
							grp_q.insert(grp_q.size(), mk_beat(KIND_SEG_END, $urandom(),
								data_t'($urandom()), 1'b0, 1'b0, rcnt_t'($urandom())));
						end else begin
							grp_q.insert(grp_q.size(), mk_beat(KIND_BYTE, next_seq + i,
								data_t'($urandom()), i == len - 1, 1'b0, rcnt_t'($urandom())));
						end
					end
					next_seq = next_seq + len;
				end
				// reorder the group half of the time
				if ($urandom_range(0, 1) == 1) begin
					for (int i = grp_q.size() - 1; i > 0; i--) begin
						j = $urandom_range(0, i);
						tmp = grp_q[i];
						grp_q[i] = grp_q[j];
						grp_q[j] = tmp;
					end
				end
				foreach (grp_q[i])
					send_beat(grp_q[i], '0);
				sent += grp_q.size();
			end
		end
	endtask

	// fill every hole, then end the stream and poke it once it has ended
	task automatic run_close();
		do begin
			send_beat(mk_beat(KIND_READ, '0, '0, 1'b0, 1'b0, 6'd63), '0);
			send_beat(mk_beat(KIND_BYTE, ack_head, data_t'($urandom()), 1'b0, 1'b0, '0), '0);
		end while (held_count() != 0);
		send_beat(mk_beat(KIND_SEG_END, '0, '0, 1'b0, 1'b1, '0), '0);
		send_beat(mk_beat(KIND_BYTE, ack_head + 40, 8'h3C, 1'b1, 1'b0, '0), '0);
		send_beat(mk_beat(KIND_SEG_END, '0, '0, 1'b0, 1'b0, '0), '0);
		send_beat(mk_beat(KIND_READ, '0, '0, 1'b0, 1'b0, 6'd5), '0);
		send_beat(mk_beat(KIND_BYTE, ack_head, 8'hC3, 1'b1, 1'b1, '0), '0);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0h byte %0h ack %0h",
					$time, result_if.out_kind, result_if.out_byte, result_if.ack_seq);
				errors++;
			end else begin
				got_want = expected_results[0];
				expected_results.delete(0);
				check_field("out_kind", 32'(got_want.out_kind), 32'(result_if.out_kind));
				check_field("out_byte", 32'(got_want.out_byte), 32'(result_if.out_byte));
				check_field("ack_seq", got_want.ack, result_if.ack_seq);
				check_field("pending_count", 32'(got_want.pend), 32'(result_if.pending_count));
				check_field("stream_ended", 32'(got_want.ended), 32'(result_if.stream_ended));
				check_field("last", 32'(got_want.last), 32'(result_if.last));
				n_results++;
				if (got_want.out_kind == OUT_DATA)
					n_data++;
			end
		end
	end

	// result side ready with random stalls and one long hold-off
	initial begin
		int stall;
		bit held;
		stall = 0;
		held = 1'b0;
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && beats_in >= 110) begin
				held = 1'b1;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (stall > 0) begin
				result_if.ready <= 1'b0;
				stall--;
			end else begin
				result_if.ready <= 1'b1;
				stall = idle_len();
			end
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// reset, directed table, random traffic, stream close
	initial begin
		arst_n               = 1'b0;
		item_if.valid        = 1'b0;
		item_if.kind         = KIND_BYTE;
		item_if.stream_index = '0;
		item_if.data_byte    = '0;
		item_if.segment_end  = 1'b0;
		item_if.eof_mark     = 1'b0;
		item_if.read_count   = '0;
		clear_window();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_ROWS; i++)
			send_beat(dir_rows[i].b, dir_rows[i].chk);
		run_random();
		run_close();
		drop_valid();

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d input beats, %0d results checked (%0d data bytes, longest release %0d)",
			beats_in, n_results, n_data, max_drain);
		$display("final ack index %0d, stream ended %0b, %0d mismatches",
			ack_head, ended_q, errors);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
